/* rtl/dacs_pkg.sv */
// dacs_pkg: shared constants, codes and result types of the avp code scanner
// no dependencies; used by the channel interfaces and every module

package dacs_pkg;

    localparam int MAX_MATCHES  = 16;
    localparam int REGION_BYTES = 65536;

    localparam int POS_W  = $clog2(REGION_BYTES + 1);
    localparam int NEXT_W = $clog2(REGION_BYTES + (1 << 24));
    localparam int CNT_W  = $clog2(MAX_MATCHES + 1);

    localparam int OFF_W   = 16;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        KIND_MATCH   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_NONE      = 3'd1,
        ST_ZERO_LEN  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    typedef struct packed
    {
        kind_t                kind;
        logic [OFF_W-1:0]     avp_offset;
        logic [OFF_W-1:0]     data_offset;
        logic [IDX_W-1:0]     match_index;
        logic [COUNT_W-1:0]   match_count;
        status_t              status;
        logic                 end_of_run;
    } result_t;

    // up to two results per byte: a match and the summary
    typedef struct packed
    {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

endpackage

/* rtl/dacs_if.sv */
// dacs_if: valid/ready channel interfaces for bytes in, results out and config
// depends on dacs_pkg

interface dacs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dacs_result_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [dacs_pkg::OFF_W-1:0]    avp_offset;
    logic [dacs_pkg::OFF_W-1:0]    data_offset;
    logic [dacs_pkg::IDX_W-1:0]    match_index;
    logic [dacs_pkg::COUNT_W-1:0]  match_count;
    logic [2:0]                    status;
    logic                          end_of_run;

    modport source (output valid, kind, avp_offset, data_offset, match_index,
                    match_count, status, end_of_run, input ready);
    modport sink   (input valid, kind, avp_offset, data_offset, match_index,
                    match_count, status, end_of_run, output ready);
endinterface

interface dacs_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_code;

    modport source (output valid, target_code, input ready);
    modport sink   (input valid, target_code, output ready);
endinterface

/* rtl/dacs_scan.sv */
// dacs_scan: input byte register and per-byte header scan state
// depends on dacs_pkg; pushes up to two results per byte into dacs_queue

module dacs_scan
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic [31:0]          target_code,
    input  logic                 queue_room,
    output dacs_pkg::push_t      push
);

    typedef enum logic [2:0]
    {
        MODE_SCAN = 3'd0,
        MODE_FULL = 3'd1,
        MODE_ZERO = 3'd2,
        MODE_LONG = 3'd4
    } mode_t;

    localparam logic [dacs_pkg::POS_W-1:0] POS_LIMIT =
        dacs_pkg::POS_W'(dacs_pkg::REGION_BYTES);
    localparam logic [dacs_pkg::CNT_W-1:0] CNT_LIMIT =
        dacs_pkg::CNT_W'(dacs_pkg::MAX_MATCHES);

    logic                          stg_valid_reg;
    logic [7:0]                    stg_byte_reg;
    logic                          stg_last_reg;
    logic [dacs_pkg::POS_W-1:0]    pos_reg,   pos_next;
    logic [dacs_pkg::NEXT_W-1:0]   start_reg, start_next;
    logic [63:0]                   shift_reg, shift_next;
    logic [3:0]                    fill_reg,  fill_next;
    logic [dacs_pkg::CNT_W-1:0]    found_reg, found_next;
    mode_t                         mode_reg,  mode_next;

    logic                          accept;
    logic                          advance;
    logic                          hit;
    logic [24:0]                   len_p3;
    logic [24:0]                   pad;
    dacs_pkg::result_t             match_item;
    dacs_pkg::result_t             summary_item;
    dacs_pkg::status_t             status_sel;

    assign in_ready = !stg_valid_reg || queue_room;
    assign accept   = in_valid && in_ready;
    assign advance  = stg_valid_reg && queue_room;

    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        shift_next = shift_reg;
        fill_next  = fill_reg;
        found_next = found_reg;
        mode_next  = mode_reg;
        hit        = 1'b0;
        len_p3     = {1'b0, shift_reg[15:0], stg_byte_reg} + 25'd3;
        pad        = {len_p3[24:2], 2'b00};

        if (mode_reg == MODE_SCAN)
        begin
            if (pos_reg >= POS_LIMIT)
            begin
                mode_next = MODE_LONG;
            end
            else if (fill_reg != 4'd0 ||
                     dacs_pkg::NEXT_W'(pos_reg) == start_reg)
            begin
                shift_next = {shift_reg[55:0], stg_byte_reg};
                fill_next  = fill_reg + 4'd1;
                if (fill_reg == 4'd7)
                begin
                    fill_next = 4'd0;
                    if (shift_next[23:0] == 24'd0)
                    begin
                        mode_next = MODE_ZERO;
                    end
                    else
                    begin
                        if (shift_next[63:32] == target_code)
                        begin
                            hit        = 1'b1;
                            found_next = found_reg + 1'b1;
                            if (found_next >= CNT_LIMIT)
                            begin
                                mode_next = MODE_FULL;
                            end
                        end
                        start_next = start_reg + dacs_pkg::NEXT_W'(pad);
                        // overlapping next header reuses the last four bytes
                        if (mode_next == MODE_SCAN && pad == 25'd4)
                        begin
                            shift_next = {32'd0, shift_next[31:0]};
                            fill_next  = 4'd4;
                        end
                    end
                end
            end
        end

        if (pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + 1'b1;
        end

        priority if (mode_next == MODE_ZERO)
            status_sel = dacs_pkg::ST_ZERO_LEN;
        else if (mode_next == MODE_LONG)
            status_sel = dacs_pkg::ST_TOO_LONG;
        else if (mode_next == MODE_FULL)
            status_sel = dacs_pkg::ST_OK;
        else if (fill_next != 4'd0)
            status_sel = dacs_pkg::ST_TRUNCATED;
        else if (found_next != '0)
            status_sel = dacs_pkg::ST_OK;
        else
            status_sel = dacs_pkg::ST_NONE;

        match_item.kind        = dacs_pkg::KIND_MATCH;
        match_item.avp_offset  = dacs_pkg::OFF_W'(start_reg);
        match_item.data_offset = dacs_pkg::OFF_W'(start_reg) +
                                 (shift_next[31] ? 16'd12 : 16'd8);
        match_item.match_index = dacs_pkg::IDX_W'(found_reg);
        match_item.match_count = '0;
        match_item.status      = dacs_pkg::ST_OK;
        match_item.end_of_run  = 1'b0;

        summary_item.kind        = dacs_pkg::KIND_SUMMARY;
        summary_item.avp_offset  = '0;
        summary_item.data_offset = '0;
        summary_item.match_index = '0;
        summary_item.match_count = dacs_pkg::COUNT_W'(found_next);
        summary_item.status      = status_sel;
        summary_item.end_of_run  = 1'b1;

        push.first_valid  = advance && (hit || stg_last_reg);
        push.second_valid = advance && hit && stg_last_reg;
        push.first        = hit ? match_item : summary_item;
        push.second       = summary_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            stg_byte_reg  <= '0;
            stg_last_reg  <= 1'b0;
            pos_reg       <= '0;
            start_reg     <= '0;
            shift_reg     <= '0;
            fill_reg      <= '0;
            found_reg     <= '0;
            mode_reg      <= MODE_SCAN;
        end
        else
        begin
            if (accept)
            begin
                stg_valid_reg <= 1'b1;
                stg_byte_reg  <= in_byte;
                stg_last_reg  <= in_last;
            end
            else if (advance)
            begin
                stg_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (stg_last_reg)
                begin
                    pos_reg   <= '0;
                    start_reg <= '0;
                    shift_reg <= '0;
                    fill_reg  <= '0;
                    found_reg <= '0;
                    mode_reg  <= MODE_SCAN;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    start_reg <= start_next;
                    shift_reg <= shift_next;
                    fill_reg  <= fill_next;
                    found_reg <= found_next;
                    mode_reg  <= mode_next;
                end
            end
        end
    end

    a_found_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= CNT_LIMIT)
        else $error("match count above limit");

    a_full_means_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_FULL) |-> (found_reg == CNT_LIMIT))
        else $error("stopped mode without reaching match limit");

    a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stg_last_reg) |=>
        (pos_reg == '0 && found_reg == '0 && fill_reg == 4'd0))
        else $error("run state not cleared after summary");

endmodule

/* rtl/dacs_queue.sv */
// dacs_queue: four-entry result queue, two writes and one read per cycle
// depends on dacs_pkg; fed by dacs_scan

module dacs_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dacs_pkg::push_t      push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dacs_pkg::result_t    out_item
);

    dacs_pkg::result_t             mem [dacs_pkg::QUEUE_DEPTH];
    logic [dacs_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [dacs_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [dacs_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          pop;
    logic [dacs_pkg::QCNT_W-1:0]   push_cnt;

    assign room      = count_reg <= dacs_pkg::QCNT_W'(dacs_pkg::QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_cnt  = dacs_pkg::QCNT_W'(push.first_valid) +
                       dacs_pkg::QCNT_W'(push.second_valid);
    assign count_next = count_reg + push_cnt - dacs_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + dacs_pkg::QPTR_W'(push_cnt);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dacs_pkg::QCNT_W'(dacs_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.first_valid || push.second_valid) |-> room)
        else $error("results pushed without two free entries");

    a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> push.first_valid)
        else $error("second result slot used alone");

endmodule

/* rtl/diameter_avp_code_scanner_core.sv */
// diameter_avp_code_scanner_core: top level of the avp code scanner
// depends on dacs_pkg, dacs_if, dacs_scan and dacs_queue
//
// Takes one byte of a Diameter AVP region per cycle, last byte marked, and
// emits a match record for each AVP whose code equals target_code (up to
// sixteen per region) followed by a summary with the match count and status.
// A byte passes an input register and the combinational header logic, and
// results leave through a four-entry queue; bytes are accepted every cycle
// while it has two free entries, which only a consumer holding ready low can
// take away. No clearing pass after reset. cfg is always ready; the user must
// write target_code only while the block is idle, which it does not enforce.

module diameter_avp_code_scanner_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    dacs_byte_if.sink            bytes,
    dacs_result_if.source        results,
    dacs_cfg_if.sink             cfg
);

    logic [31:0]         target_code_reg;
    logic                queue_room;
    dacs_pkg::push_t     push;
    dacs_pkg::result_t   head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_code_reg <= '0;
        end
        else if (cfg.valid)
        begin
            target_code_reg <= cfg.target_code;
        end
    end

    dacs_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (bytes.valid),
        .in_ready    (bytes.ready),
        .in_byte     (bytes.data_byte),
        .in_last     (bytes.last_byte),
        .target_code (target_code_reg),
        .queue_room  (queue_room),
        .push        (push)
    );

    dacs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (queue_room),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_item  (head)
    );

    assign results.kind        = head.kind;
    assign results.avp_offset  = head.avp_offset;
    assign results.data_offset = head.data_offset;
    assign results.match_index = head.match_index;
    assign results.match_count = head.match_count;
    assign results.status      = head.status;
    assign results.end_of_run  = head.end_of_run;

endmodule
